@@ hdl/aroon_window_extremum_age_defines.svh @@
// Assertion macros used by the port-level checker of the aroon block.
// Depends on nothing; guarded against repeated inclusion.
`ifndef AROON_WINDOW_EXTREMUM_AGE_DEFINES_SVH
`define AROON_WINDOW_EXTREMUM_AGE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define AWE_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AWE_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ hdl/awe_pkg.sv @@
// Package of the aroon block: widths, constants and the shared job struct.
// Depends on nothing.
package awe_pkg;
  localparam int MaxWindow = 64;
  localparam int PriceBits = 32;
  localparam int SlotBits = $clog2(MaxWindow);
  localparam int AgeBits = $clog2(MaxWindow + 1);
  localparam int CfgBits = 7;
  localparam logic [CfgBits-1:0] DefaultWindow = 7'd14;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SCAN, ST_DIV, ST_OUT
  } back_state_t;

  // One classified bar handed from front to back.
  typedef struct packed {
    logic [PriceBits-1:0] hi;
    logic [PriceBits-1:0] lo;
    logic [SlotBits-1:0]  slot;
    logic                 warm;
  } job_t;
endpackage

@@ hdl/aroon_window_extremum_age.sv @@
// Top level of the aroon indicator block.
// Depends on awe_pkg, awe_front and awe_back.
// Each accepted bar transaction enters a two-entry queue in the front end and
// is processed by the back end one at a time, so up to two bars can still be
// taken while a result waits. Warm-up bars, the first window bars after reset
// or a window write, give no result and are done in the back end at the take.
// A bar that keeps both extremes in the window passes through the take, a
// store read, a divider setup, seven restoring divide steps and the output
// state. A bar that pushes an extreme out of the window rescans it through
// the store's read port, one bar per cycle, before the divide. Window writes
// must be made only while no bar is in flight; a write clears the bar count
// and both ages.
module aroon_window_extremum_age (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [awe_pkg::CfgBits-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [awe_pkg::PriceBits-1:0] high_price,
  input  logic [awe_pkg::PriceBits-1:0] low_price,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  aroon_up,
  output logic [6:0]  aroon_down,
  output logic signed [7:0] oscillator
);
  logic [awe_pkg::CfgBits-1:0] wreg;
  logic [awe_pkg::AgeBits-1:0] win;
  logic clr, qv, qr;
  awe_pkg::job_t job;

  assign cfg_ready = 1'b1;
  assign clr = cfg_valid && cfg_ready;
  // Effective window: zero is used as one, large values clamp.
  assign win = (wreg == '0) ? awe_pkg::AgeBits'(1) :
               (wreg > awe_pkg::CfgBits'(awe_pkg::MaxWindow)) ?
               awe_pkg::AgeBits'(awe_pkg::MaxWindow) : awe_pkg::AgeBits'(wreg);

  always_ff @(posedge clk) begin
    if (rst) wreg <= awe_pkg::DefaultWindow;
    else if (clr) wreg <= cfg_data;
  end

  awe_front u_front (.clk, .rst, .in_valid, .in_ready, .high_price, .low_price,
    .clr, .win, .q_valid(qv), .q_ready(qr), .q_job(job));
  awe_back u_back (.clk, .rst, .clr, .win, .j_valid(qv), .j_ready(qr), .job,
    .out_valid, .out_ready, .aroon_up, .aroon_down, .oscillator);
endmodule

@@ hdl/awe_front.sv @@
// Front end: accepts bars, assigns store slots and flags warm-up bars.
// Depends on awe_pkg.
module awe_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [awe_pkg::PriceBits-1:0] high_price,
  input  logic [awe_pkg::PriceBits-1:0] low_price,
  input  logic                       clr,
  input  logic [awe_pkg::AgeBits-1:0] win,
  output logic                       q_valid,
  input  logic                       q_ready,
  output awe_pkg::job_t              q_job
);
  localparam int CntW = $clog2(awe_pkg::QueueDepth + 1);
  logic [awe_pkg::SlotBits-1:0] wslot;
  logic [awe_pkg::AgeBits:0] seen;
  awe_pkg::job_t q [awe_pkg::QueueDepth];
  awe_pkg::job_t job_in;
  logic [CntW-1:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != CntW'(awe_pkg::QueueDepth));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != '0);
  assign pop = q_valid && q_ready;
  assign q_job = q[0];
  assign job_in = '{high_price, low_price, wslot, (seen + 1'b1) <= {1'b0, win}};

  always_ff @(posedge clk) begin
    if (rst) begin
      wslot <= '0;
      seen <= '0;
      cnt <= '0;
    end else begin
      if (clr) seen <= '0;
      else if (push && seen <= (awe_pkg::AgeBits+1)'(awe_pkg::MaxWindow))
        seen <= seen + 1'b1;
      if (push) wslot <= wslot + 1'b1;
      cnt <= cnt + CntW'(push) - CntW'(pop);
    end
  end

  // A new bar lands at the head when the queue is empty or the head leaves.
  always_ff @(posedge clk) begin
    if (push && (cnt == '0 || pop)) q[0] <= job_in;
    else if (pop) q[0] <= q[1];
    if (push && !pop && cnt == CntW'(1)) q[1] <= job_in;
  end
endmodule

@@ hdl/awe_back.sv @@
// Back end: bar store, age tracking, rescan and percentage division.
// Depends on awe_pkg.
module awe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic [awe_pkg::AgeBits-1:0] win,
  input  logic                        j_valid,
  output logic                        j_ready,
  input  awe_pkg::job_t               job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [6:0]                  aroon_up,
  output logic [6:0]                  aroon_down,
  output logic [7:0]                  oscillator
);
  localparam int AW = awe_pkg::AgeBits;
  localparam int SW = awe_pkg::SlotBits;
  localparam int PW = awe_pkg::PriceBits;
  localparam logic [AW-1:0] Out = AW'(awe_pkg::MaxWindow);

  logic [PW-1:0] hmem [awe_pkg::MaxWindow];
  logic [PW-1:0] lmem [awe_pkg::MaxWindow];
  logic [PW-1:0] rh, rl, bh, bl, jh, jl;
  logic [SW-1:0] jslot, hraddr, lraddr;
  logic [AW-1:0] hage, lage, sage, dage, hnew, lnew, hfin, lfin;
  logic rescan, take;
  logic [2:0] dcnt;
  logic [13:0] nh, nl, dv;
  logic [6:0] up, dn;
  awe_pkg::back_state_t st, st_next;

  assign j_ready = (st == awe_pkg::ST_IDLE);
  assign take = j_valid && j_ready;
  assign hnew = (hage >= Out) ? Out : hage + 1'b1;
  assign lnew = (lage >= Out) ? Out : lage + 1'b1;
  // Without a rescan a bar that ties or beats the tracked extreme takes it.
  assign hfin = (!rescan && jh >= rh) ? '0 : hage;
  assign lfin = (!rescan && jl <= rl) ? '0 : lage;
  // A rescan walks one age on both stores; otherwise each reads its extreme.
  assign hraddr = jslot - SW'(rescan ? sage : hage);
  assign lraddr = jslot - SW'(rescan ? sage : lage);

  always_comb begin
    st_next = st;
    unique case (st)
      awe_pkg::ST_IDLE: if (take && !job.warm) st_next = awe_pkg::ST_READ;
      awe_pkg::ST_READ: st_next = rescan ? awe_pkg::ST_SCAN : awe_pkg::ST_DIV;
      awe_pkg::ST_SCAN: if (dage == '0) st_next = awe_pkg::ST_DIV;
      awe_pkg::ST_DIV: if (dcnt == 3'd7) st_next = awe_pkg::ST_OUT;
      awe_pkg::ST_OUT: if (out_ready) st_next = awe_pkg::ST_IDLE;
      default: st_next = awe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (st == awe_pkg::ST_OUT);
    aroon_up = up;
    aroon_down = dn;
    oscillator = {1'b0, up} - {1'b0, dn};
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hmem[job.slot] <= job.hi;
      lmem[job.slot] <= job.lo;
    end
    rh <= hmem[hraddr];
    rl <= lmem[lraddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= awe_pkg::ST_IDLE;
      hage <= Out;
      lage <= Out;
    end else begin
      st <= st_next;
      if (clr) begin
        hage <= Out;
        lage <= Out;
      end else begin
        unique case (st)
          awe_pkg::ST_IDLE: if (take) begin
            if (job.warm) begin
              hage <= Out; lage <= Out;
            end else begin
              hage <= hnew; lage <= lnew;
            end
          end
          awe_pkg::ST_SCAN: begin
            // The oldest bar seeds both extremes; later ones must be strictly better.
            if (dage == win - 1'b1) begin
              hage <= dage; lage <= dage;
            end else begin
              if (rh > bh) hage <= dage;
              if (rl < bl) lage <= dage;
            end
          end
          awe_pkg::ST_DIV: if (dcnt == '0) begin
            hage <= hfin; lage <= lfin;
          end
          default: ;
        endcase
      end
    end
  end

  // Scan pointers and a restoring divider: a setup step, then seven divide steps.
  always_ff @(posedge clk) begin
    unique case (st)
      awe_pkg::ST_IDLE: if (take) begin
        jh <= job.hi; jl <= job.lo; jslot <= job.slot;
        dcnt <= '0;
        rescan <= (hnew >= win) || (lnew >= win);
        sage <= win - 1'b1;
      end
      awe_pkg::ST_READ: begin
        // rh and rl are registered reads, so they trail the read age held in sage.
        dage <= sage;
        sage <= sage - 1'b1;
      end
      awe_pkg::ST_SCAN: begin
        if (dage == win - 1'b1) begin
          bh <= rh; bl <= rl;
        end else begin
          if (rh > bh) bh <= rh;
          if (rl < bl) bl <= rl;
        end
        dage <= dage - 1'b1;
        sage <= sage - 1'b1;
      end
      awe_pkg::ST_DIV: begin
        dcnt <= dcnt + 1'b1;
        if (dcnt == '0) begin
          nh <= 14'd100 * 14'(win - hfin);
          nl <= 14'd100 * 14'(win - lfin);
          dv <= {1'b0, win, 6'd0};
          up <= '0; dn <= '0;
        end else begin
          if (nh >= dv) begin
            nh <= nh - dv; up <= {up[5:0], 1'b1};
          end else up <= {up[5:0], 1'b0};
          if (nl >= dv) begin
            nl <= nl - dv; dn <= {dn[5:0], 1'b1};
          end else dn <= {dn[5:0], 1'b0};
          dv <= dv >> 1;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ hdl/awe_checker.sv @@
// Port-level checker for the aroon block, bound to the top level.
// Depends on the defines header.
`include "aroon_window_extremum_age_defines.svh"
module awe_checker (
  input logic clk, input logic rst, input logic out_valid, input logic out_ready,
  input logic [6:0] aroon_up, input logic [6:0] aroon_down,
  input logic [7:0] oscillator
);
  logic [7:0] osc_exp;
  assign osc_exp = {1'b0, aroon_up} - {1'b0, aroon_down};

  `AWE_ASSERT_IMP(up_range, clk, rst, out_valid, aroon_up <= 7'd100)
  `AWE_ASSERT_IMP(dn_range, clk, rst, out_valid, aroon_down <= 7'd100)
  `AWE_ASSERT_IMP(osc_diff, clk, rst, out_valid, oscillator == osc_exp)
  `AWE_ASSERT_NXT(hold, clk, rst, out_valid && !out_ready, out_valid && $stable(aroon_up))
endmodule
bind aroon_window_extremum_age awe_checker u_chk (.clk, .rst, .out_valid, .out_ready,
  .aroon_up, .aroon_down, .oscillator);

@@ tb/aroon_window_extremum_age_checker.sv @@
// Scoreboard for the aroon block: watches bar, window and result transactions.
// Depends on awe_pkg; predicts each result and compares it field by field.
module aroon_window_extremum_age_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [6:0]        cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [31:0]       high_price,
  input  logic [31:0]       low_price,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [6:0]        aroon_up,
  input  logic [6:0]        aroon_down,
  input  logic signed [7:0] oscillator,
  output int                error_count,
  output int                pending_count,
  output int                result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] up;
    logic [6:0] down;
    logic [7:0] osc;
  } aroon_t;

  logic [awe_pkg::PriceBits-1:0] bar_high [awe_pkg::MaxWindow];
  logic [awe_pkg::PriceBits-1:0] bar_low [awe_pkg::MaxWindow];
  int unsigned slot_ptr, bar_count, high_age, low_age;
  logic [awe_pkg::CfgBits-1:0] window_reg;
  aroon_t pending_results[$];

  function automatic int unsigned slot_at(int unsigned age);
    return (slot_ptr + awe_pkg::MaxWindow - age) % awe_pkg::MaxWindow;
  endfunction

  // Advances the window by one bar; returns 1 and the result when one is due.
  function automatic bit aroon_next(input logic [31:0] hi, input logic [31:0] lo,
                                    output aroon_t res);
    int unsigned w, up, down;
    logic [31:0] best_hi, best_lo;
    w = (window_reg == 0) ? 1 :
        (window_reg > awe_pkg::MaxWindow) ? awe_pkg::MaxWindow : window_reg;
    bar_high[slot_ptr] = hi;
    bar_low[slot_ptr] = lo;
    if (bar_count <= awe_pkg::MaxWindow) bar_count++;
    high_age = (high_age >= awe_pkg::MaxWindow) ? awe_pkg::MaxWindow : high_age + 1;
    low_age = (low_age >= awe_pkg::MaxWindow) ? awe_pkg::MaxWindow : low_age + 1;
    if (bar_count <= w) begin
      high_age = awe_pkg::MaxWindow;
      low_age = awe_pkg::MaxWindow;
      slot_ptr = (slot_ptr + 1) % awe_pkg::MaxWindow;
      return 0;
    end
    if (high_age >= w || low_age >= w) begin
      // Rescan oldest to newest; only a strictly better bar moves an extreme.
      best_hi = bar_high[slot_at(w - 1)];
      best_lo = bar_low[slot_at(w - 1)];
      high_age = w - 1;
      low_age = w - 1;
      for (int a = w - 1; a > 0; a--) begin
        if (bar_high[slot_at(a - 1)] > best_hi) begin
          best_hi = bar_high[slot_at(a - 1)];
          high_age = a - 1;
        end
        if (bar_low[slot_at(a - 1)] < best_lo) begin
          best_lo = bar_low[slot_at(a - 1)];
          low_age = a - 1;
        end
      end
    end else begin
      if (hi >= bar_high[slot_at(high_age)]) high_age = 0;
      if (lo <= bar_low[slot_at(low_age)]) low_age = 0;
    end
    up = (100 * (w - high_age)) / w;
    down = (100 * (w - low_age)) / w;
    res.up = up[6:0];
    res.down = down[6:0];
    res.osc = 8'(up - down);
    slot_ptr = (slot_ptr + 1) % awe_pkg::MaxWindow;
    return 1;
  endfunction

  always @(posedge clk) begin
    aroon_t res, exp_res;
    if (rst) begin
      slot_ptr = 0;
      bar_count = 0;
      high_age = awe_pkg::MaxWindow;
      low_age = awe_pkg::MaxWindow;
      window_reg = awe_pkg::DefaultWindow;
      pending_results.delete();
      error_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_reg = cfg_data;
        bar_count = 0;
        high_age = awe_pkg::MaxWindow;
        low_age = awe_pkg::MaxWindow;
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (pending_results.size() == 0) begin
          $error("unexpected result: up %0d down %0d", aroon_up, aroon_down);
          error_count <= error_count + 1;
        end else begin
          exp_res = pending_results.pop_front();
          if (aroon_up !== exp_res.up || aroon_down !== exp_res.down ||
              oscillator !== exp_res.osc) begin
            error_count <= error_count + 1;
            if (aroon_up !== exp_res.up)
              $error("aroon_up: expected %0d, got %0d", exp_res.up, aroon_up);
            if (aroon_down !== exp_res.down)
              $error("aroon_down: expected %0d, got %0d", exp_res.down, aroon_down);
            if (oscillator !== exp_res.osc)
              $error("oscillator: expected %0d, got %0d",
                     $signed(exp_res.osc), oscillator);
          end
        end
      end
      if (in_valid && in_ready && aroon_next(high_price, low_price, res))
        pending_results.push_back(res);
    end
    pending_count <= pending_results.size();
  end
endmodule

@@ tb/tb_aroon_window_extremum_age.sv @@
// Testbench top for the aroon block: clock, reset, stimulus and verdict.
// Depends on awe_pkg, the block and aroon_window_extremum_age_checker.
module tb_aroon_window_extremum_age;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 900000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [6:0] cfg_data;
  logic in_valid, in_ready;
  logic [31:0] high_price, low_price;
  logic out_valid, out_ready;
  logic [6:0] aroon_up, aroon_down;
  logic signed [7:0] oscillator;
  int error_count, pending_count, result_count;
  int send_idle_pct, recv_idle_pct;
  int cycle_count, bar_total;

  aroon_window_extremum_age u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .high_price(high_price), .low_price(low_price),
    .out_valid(out_valid), .out_ready(out_ready),
    .aroon_up(aroon_up), .aroon_down(aroon_down), .oscillator(oscillator)
  );

  aroon_window_extremum_age_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: the slowest legal run is far below this many cycles.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // The receiver stalls at random; the rate changes between phases.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one bar transaction, optionally idling before raising valid.
  // Valid stays high after acceptance so the next bar can follow directly.
  task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    high_price <= hi;
    low_price <= lo;
    bar_total++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until all predicted results are out, then lets the block settle
  // since a warm-up bar gives no result but may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (200) @(posedge clk);
  endtask

  // Window writes are made only while the block is idle.
  task automatic write_window(input logic [6:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random bar: mostly a narrow band so ties and new extremes are common,
  // sometimes full-range values so every price bit toggles.
  task automatic random_bar();
    logic [31:0] hi, lo;
    if ($urandom_range(3) == 0) begin
      hi = $urandom;
      lo = $urandom;
    end else begin
      hi = 32'd1000 + $urandom_range(20);
      lo = 32'd990 + $urandom_range(20);
    end
    send_bar(hi, lo);
  endtask

  // Trending runs drive the ages to both extremes, zero and window minus one.
  task automatic trend_run(input int n, input bit rising);
    logic [31:0] base;
    base = $urandom_range(32'h7fff_ffff, 32'h1000);
    for (int i = 0; i < n; i++) begin
      if (rising) send_bar(base + i, base + i);
      else send_bar(base - i, base - i);
    end
  endtask

  initial begin
    logic [6:0] windows [6];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    high_price = '0;
    low_price = '0;
    send_idle_pct = 7;
    recv_idle_pct = 88;
    bar_total = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset window of 14: warm-up, price extremes,
    // ties that move an extreme, and a rising run.
    for (int i = 0; i < 15; i++) send_bar(32'd500, 32'd500);
    send_bar(32'hffff_ffff, 32'h0000_0000);
    send_bar(32'hffff_ffff, 32'h0000_0000);
    send_bar(32'h0000_0000, 32'hffff_ffff);
    trend_run(7, 1'b1);

    // Window extremes: zero acts as one, above the maximum acts as the maximum.
    write_window(7'd0);
    trend_run(4, 1'b0);
    write_window(7'd127);
    trend_run(70, 1'b1);
    write_window(7'd1);
    trend_run(4, 1'b1);

    windows = '{7'd64, 7'd2, 7'd5, 7'd14, 7'd33, 7'd65};
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 88;
        recv_idle_pct = 7;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 6; k++) begin
        write_window(phase == 2 ? windows[k] : 7'($urandom_range(1, 20)));
        for (int n = 0; n < 50; n++) begin
          if ($urandom_range(9) == 0)
            trend_run($urandom_range(2, 12), 1'($urandom_range(1)));
          else random_bar();
        end
      end
      // Hold the sender back until every predicted result has come out.
      drain();
    end

    drain();
    $display("covered %0d bars and %0d results over windows 0..127 and three idle mixes",
             bar_total, result_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
